// ----- rtl/core/cps_pkg.sv -----
// Package for the column projection segmenter: sizes, limits, register
// indexes and reset values. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cps_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 256;

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int IMG_W_W = 11;
   localparam int IMG_H_W = 9;
   localparam int MINAV_W = 9;
   localparam int CNT_W   = 9;
   localparam int SUM_W   = 19;
   localparam int PIXEL_W = 8;
   localparam int START_W = 10;
   localparam int END_W   = 11;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 11;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   localparam logic [IMG_W_W-1:0] WIDTH_LIMIT  = IMG_W_W'(MAX_WIDTH);
   localparam logic [IMG_H_W-1:0] HEIGHT_LIMIT = IMG_H_W'(MAX_HEIGHT);

   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_AVERAGE  = 2'd2;

   localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 11'd1024;
   localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST = 9'd256;
   localparam logic [MINAV_W-1:0] MIN_AVERAGE_RST  = 9'd3;

endpackage

`default_nettype wire

// ----- rtl/core/column_projection_segmenter_core.sv -----
// Column projection segmenter: per-column foreground count, run tracking and
// run acceptance against a minimum average. Depends on cps_pkg.
//
//   channel | dir  | handshake          | payload
//   req     | in   | req_valid/ready    | req_pixel[7:0]
//   rsp     | out  | rsp_valid/ready    | rsp_seg_start[9:0], rsp_seg_end[10:0]
//   csr     | in   | csr_we             | csr_addr[1:0], csr_wdata[10:0]
//
// One pixel beat per cycle unless a stalled result beat holds req_ready low; a result
// beat appears in the cycle after the last pixel of the column that closes an accepted run.
// The rate is set by the single state update between the position and run
// registers and the result register.
// Synchronous active-high reset clears position, run state and the result
// valid, and loads the register defaults.
// A stalled result beat holds req_ready low only while rsp_ready is low.
`timescale 1ns / 1ps
`default_nettype none

module column_projection_segmenter_core
   import cps_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [PIXEL_W-1:0]    req_pixel,

   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [START_W-1:0]         rsp_seg_start,
   output logic [END_W-1:0]           rsp_seg_end,

   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [IMG_W_W-1:0] image_width_ff;
   logic [IMG_H_W-1:0] image_height_ff;
   logic [MINAV_W-1:0] min_average_ff;

   logic [ROW_W-1:0]   row_pos_ff,   row_pos_in;
   logic [COL_W-1:0]   col_pos_ff,   col_pos_in;
   logic [CNT_W-1:0]   col_count_ff, col_count_in;
   logic               in_run_ff,    in_run_in;
   logic [COL_W-1:0]   run_start_ff, run_start_in;
   logic [SUM_W-1:0]   run_sum_ff,   run_sum_in;
   logic [SUM_W-1:0]   run_need_ff,  run_need_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [START_W-1:0] seg_start_ff, seg_start_in;
   logic [END_W-1:0]   seg_end_ff,   seg_end_in;

   logic               req_fire;
   logic               emit;
   logic [IMG_W_W-1:0] w_eff, w_last;
   logic [IMG_H_W-1:0] h_eff, h_last;
   logic               col_done, last_col;
   logic [CNT_W-1:0]   cnt_now;
   logic [SUM_W-1:0]   base_sum, base_need, sum_new, need_new;
   logic [SUM_W:0]     sum_ext, need_ext;
   logic [COL_W-1:0]   start_now;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      // clamp the geometry registers
      if (image_width_ff == '0) begin
         w_eff = IMG_W_W'(1);
      end else if (image_width_ff > WIDTH_LIMIT) begin
         w_eff = WIDTH_LIMIT;
      end else begin
         w_eff = image_width_ff;
      end
      if (image_height_ff == '0) begin
         h_eff = IMG_H_W'(1);
      end else if (image_height_ff > HEIGHT_LIMIT) begin
         h_eff = HEIGHT_LIMIT;
      end else begin
         h_eff = image_height_ff;
      end
      w_last = w_eff - IMG_W_W'(1);
      h_last = h_eff - IMG_H_W'(1);

      col_done = (IMG_H_W'(row_pos_ff) >= h_last);
      last_col = (IMG_W_W'(col_pos_ff) >= w_last);

      cnt_now = col_count_ff;
      if (req_pixel != '0 && col_count_ff != CNT_MAX) begin
         cnt_now = col_count_ff + CNT_W'(1);
      end

      base_sum  = in_run_ff ? run_sum_ff  : '0;
      base_need = in_run_ff ? run_need_ff : '0;
      start_now = in_run_ff ? run_start_ff : col_pos_ff;

      sum_ext  = {1'b0, base_sum}  + (SUM_W+1)'(cnt_now);
      need_ext = {1'b0, base_need} + (SUM_W+1)'(min_average_ff);
      sum_new  = sum_ext[SUM_W]  ? SUM_MAX : sum_ext[SUM_W-1:0];
      need_new = need_ext[SUM_W] ? SUM_MAX : need_ext[SUM_W-1:0];

      row_pos_in   = row_pos_ff;
      col_pos_in   = col_pos_ff;
      col_count_in = col_count_ff;
      in_run_in    = in_run_ff;
      run_start_in = run_start_ff;
      run_sum_in   = run_sum_ff;
      run_need_in  = run_need_ff;
      emit         = 1'b0;
      seg_start_in = seg_start_ff;
      seg_end_in   = seg_end_ff;

      if (req_fire) begin
         if (!col_done) begin
            row_pos_in   = row_pos_ff + ROW_W'(1);
            col_count_in = cnt_now;
         end else begin
            row_pos_in   = '0;
            col_count_in = '0;
            if (cnt_now != '0) begin
               in_run_in    = 1'b1;
               run_start_in = start_now;
               run_sum_in   = sum_new;
               run_need_in  = need_new;
               if (last_col) begin
                  emit         = (sum_new >= need_new);
                  seg_start_in = START_W'(start_now);
                  seg_end_in   = END_W'(col_pos_ff) + END_W'(1);
                  in_run_in    = 1'b0;
                  run_sum_in   = '0;
                  run_need_in  = '0;
               end
            end else if (in_run_ff) begin
               emit         = (run_sum_ff >= run_need_ff);
               seg_start_in = START_W'(run_start_ff);
               seg_end_in   = END_W'(col_pos_ff);
               in_run_in    = 1'b0;
               run_sum_in   = '0;
               run_need_in  = '0;
            end
            if (last_col) begin
               col_pos_in  = '0;
               in_run_in   = 1'b0;
               run_sum_in  = '0;
               run_need_in = '0;
            end else begin
               col_pos_in = col_pos_ff + COL_W'(1);
            end
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= IMAGE_WIDTH_RST;
         image_height_ff <= IMAGE_HEIGHT_RST;
         min_average_ff  <= MIN_AVERAGE_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata[IMG_W_W-1:0];
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata[IMG_H_W-1:0];
            CSR_MIN_AVERAGE:  min_average_ff  <= csr_wdata[MINAV_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_pos_ff   <= '0;
         col_pos_ff   <= '0;
         col_count_ff <= '0;
         in_run_ff    <= 1'b0;
         run_start_ff <= '0;
         run_sum_ff   <= '0;
         run_need_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_pos_ff   <= row_pos_in;
         col_pos_ff   <= col_pos_in;
         col_count_ff <= col_count_in;
         in_run_ff    <= in_run_in;
         run_start_ff <= run_start_in;
         run_sum_ff   <= run_sum_in;
         run_need_ff  <= run_need_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seg_start_ff <= seg_start_in;
      seg_end_ff   <= seg_end_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_seg_start = seg_start_ff;
   assign rsp_seg_end   = seg_end_ff;

   a_idle_sums_clear: assert property (@(posedge clock) disable iff (reset)
      !in_run_ff |-> (run_sum_ff == '0 && run_need_ff == '0))
      else $error("run sums not cleared outside a run");

   a_open_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      in_run_ff |-> (run_sum_ff != '0))
      else $error("open run with zero sum");

   a_start_order: assert property (@(posedge clock) disable iff (reset)
      in_run_ff |-> (run_start_ff <= col_pos_ff))
      else $error("run start beyond current column");

   a_column_clear: assert property (@(posedge clock) disable iff (reset)
      (req_fire && col_done) |=> (col_count_ff == '0 && row_pos_ff == '0))
      else $error("column count not cleared at column end");

endmodule

`default_nettype wire

// ----- dv/cps_segment_checker.sv -----
// Scoreboard for column_projection_segmenter_core: follows register writes,
// predicts segment beats from accepted pixel beats and compares result beats.
// Depends on cps_pkg.
`timescale 1ns / 1ps

module cps_segment_checker
   import cps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [PIXEL_W-1:0]    req_pixel,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [START_W-1:0]    rsp_seg_start,
   input  logic [END_W-1:0]      rsp_seg_end,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatches,
   output int                    segments_pending,
   output int                    segments_checked
);

   localparam int PRINT_LIMIT = 100;

   typedef struct packed {
      logic [START_W-1:0] seg_start;
      logic [END_W-1:0]   seg_end;
   } segment_type;

   segment_type expected_segments[$];

   logic [IMG_W_W-1:0] width_reg;
   logic [IMG_H_W-1:0] height_reg;
   logic [MINAV_W-1:0] min_avg_reg;

   logic [ROW_W-1:0]   row_pos;
   logic [COL_W-1:0]   col_pos;
   logic [CNT_W-1:0]   col_count;
   logic               in_run;
   logic [COL_W-1:0]   run_start;
   logic [SUM_W-1:0]   run_sum;
   logic [SUM_W-1:0]   run_need;

   task automatic report_mismatch(input string msg);
      if (mismatches < PRINT_LIMIT) begin
         $display("%0t ns: %s", $time, msg);
      end
      mismatches++;
   endtask

   function automatic int clamp_size(input int value, input int limit);
      if (value < 1) begin
         return 1;
      end
      if (value > limit) begin
         return limit;
      end
      return value;
   endfunction

   function automatic logic [SUM_W-1:0] sum_saturate(input logic [SUM_W-1:0] acc,
                                                     input int addend);
      int total;
      total = int'(acc) + addend;
      return (total > int'(SUM_MAX)) ? SUM_MAX : SUM_W'(total);
   endfunction

   // close the open run; keep it only if its sum reaches the required total
   task automatic end_run(input int end_col);
      segment_type seg;
      if (run_sum >= run_need) begin
         seg.seg_start = run_start;
         seg.seg_end   = END_W'(end_col);
         expected_segments = {expected_segments, seg};
      end
      in_run   = 1'b0;
      run_sum  = '0;
      run_need = '0;
   endtask

   task automatic project_pixel(input logic [PIXEL_W-1:0] px);
      int width_eff;
      int height_eff;
      int count;
      logic last_col;
      width_eff  = clamp_size(int'(width_reg), MAX_WIDTH);
      height_eff = clamp_size(int'(height_reg), MAX_HEIGHT);
      if (px != '0 && col_count != CNT_MAX) begin
         col_count = col_count + 1'b1;
      end
      if (int'(row_pos) < height_eff - 1) begin
         row_pos = row_pos + 1'b1;
         return;
      end
      count     = int'(col_count);
      col_count = '0;
      row_pos   = '0;
      last_col  = (int'(col_pos) >= width_eff - 1);
      if (count != 0) begin
         if (!in_run) begin
            in_run    = 1'b1;
            run_start = col_pos;
            run_sum   = '0;
            run_need  = '0;
         end
         run_sum  = sum_saturate(run_sum, count);
         run_need = sum_saturate(run_need, int'(min_avg_reg));
         if (last_col) begin
            end_run(int'(col_pos) + 1);
         end
      end else if (in_run) begin
         end_run(int'(col_pos));
      end
      if (last_col) begin
         col_pos = '0;
      end else begin
         col_pos = col_pos + 1'b1;
      end
   endtask

   always @(posedge clock) begin : monitor
      segment_type want;
      if (reset) begin
         width_reg   = IMAGE_WIDTH_RST;
         height_reg  = IMAGE_HEIGHT_RST;
         min_avg_reg = MIN_AVERAGE_RST;
         row_pos     = '0;
         col_pos     = '0;
         col_count   = '0;
         in_run      = 1'b0;
         run_start   = '0;
         run_sum     = '0;
         run_need    = '0;
         expected_segments.delete();
      end else begin
         // compare first: a pixel accepted on this edge cannot yield this beat
         if (rsp_valid && rsp_ready) begin
            if (expected_segments.size() == 0) begin
               report_mismatch($sformatf("segment [%0d, %0d) with none predicted",
                                         rsp_seg_start, rsp_seg_end));
            end else begin
               want = expected_segments.pop_front();
               if (rsp_seg_start !== want.seg_start) begin
                  report_mismatch($sformatf("seg_start: got %0d, expected %0d",
                                            rsp_seg_start, want.seg_start));
               end
               if (rsp_seg_end !== want.seg_end) begin
                  report_mismatch($sformatf("seg_end: got %0d, expected %0d",
                                            rsp_seg_end, want.seg_end));
               end
               segments_checked++;
            end
         end
         if (req_valid && req_ready) begin
            project_pixel(req_pixel);
         end
         if (csr_we) begin
            case (csr_addr)
               CSR_IMAGE_WIDTH: begin
                  width_reg = csr_wdata[IMG_W_W-1:0];
               end
               CSR_IMAGE_HEIGHT: begin
                  height_reg = csr_wdata[IMG_H_W-1:0];
               end
               CSR_MIN_AVERAGE: begin
                  min_avg_reg = csr_wdata[MINAV_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
      segments_pending = expected_segments.size();
   end

endmodule

// ----- dv/tb_top.sv -----
// Top of the column projection segmenter testbench: clock, reset, pixel and
// register stimulus, result sink and verdict. Depends on cps_pkg,
// column_projection_segmenter_core and cps_segment_checker.
`timescale 1ns / 1ps

module tb_top;
   import cps_pkg::*;

   localparam int HALF_PERIOD    = 4;
   localparam int RESET_CYCLES   = 7;
   localparam int RANDOM_PIXELS  = 1450;
   localparam int HOLD_PHASE     = 3;
   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = 4;
   localparam int DRAIN_CYCLES   = 16;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam logic [CSR_ADDR_W-1:0] CSR_UNMAPPED = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [PIXEL_W-1:0]    req_pixel = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [START_W-1:0]    rsp_seg_start;
   logic [END_W-1:0]      rsp_seg_end;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic tx_burst  = 1'b0;
   logic rx_burst  = 1'b0;
   logic hold_sink = 1'b0;
   int   pixels_sent = 0;
   int   settings_used = 0;
   int   idle_cycles = 0;
   int   mismatches;
   int   segments_pending;
   int   segments_checked;

   always #(HALF_PERIOD) clock = ~clock;

   column_projection_segmenter_core DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_pixel     (req_pixel),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_seg_start (rsp_seg_start),
      .rsp_seg_end   (rsp_seg_end),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata)
   );

   cps_segment_checker segment_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel        (req_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_seg_start    (rsp_seg_start),
      .rsp_seg_end      (rsp_seg_end),
      .csr_we           (csr_we),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata),
      .mismatches       (mismatches),
      .segments_pending (segments_pending),
      .segments_checked (segments_checked)
   );

   // entered and left at a falling edge; valid stays high across back-to-back beats
   task automatic send_pixel(input logic [PIXEL_W-1:0] value);
      int gap;
      gap = tx_burst ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= value;
      do @(posedge clock); while (!req_ready);
      pixels_sent++;
      @(negedge clock);
   endtask

   task automatic load_config(input logic [CSR_DATA_W-1:0] width_val,
                              input logic [CSR_DATA_W-1:0] height_val,
                              input logic [CSR_DATA_W-1:0] min_avg_val);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_IMAGE_WIDTH;
      csr_wdata <= width_val;
      @(negedge clock);
      csr_addr  <= CSR_IMAGE_HEIGHT;
      csr_wdata <= height_val;
      @(negedge clock);
      csr_addr  <= CSR_MIN_AVERAGE;
      csr_wdata <= min_avg_val;
      @(negedge clock);
      csr_addr  <= CSR_UNMAPPED;
      csr_wdata <= CSR_DATA_W'($urandom_range(0, 2047));
      @(negedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // drop valid, wait for every predicted segment, then let the pipeline settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(negedge clock); while (segments_pending != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin : receiver
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_sink) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_sink = 1'b0;
         end
         stall = rx_burst ? 0 : $urandom_range(0, 19);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no beat on either channel for %0d cycles", WATCHDOG_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin : stimulus
      int phase;
      int random_sent;
      int len;
      int h_eff;
      int empty_pct;
      int density;
      int stim_row;
      logic noise;
      logic empty_col;
      logic [CSR_DATA_W-1:0] w_val;
      logic [CSR_DATA_W-1:0] h_val;
      logic [CSR_DATA_W-1:0] m_val;
      logic [PIXEL_W-1:0] px;

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset defaults, runs closed by an empty column and by the
      // last column, zero minimum, unreachable minimum, clamped sizes and a
      // height change in the middle of a column
      tx_burst = 1'b1;
      send_pixel(8'hFF);
      wait_idle();
      load_config(11'd4, 11'd2, 11'd0);
      send_pixel(8'h00); send_pixel(8'hFF); send_pixel(8'h01); send_pixel(8'h80);
      send_pixel(8'h00); send_pixel(8'h00); send_pixel(8'h55); send_pixel(8'hAA);
      wait_idle();
      load_config(11'd1, 11'd1, 11'h1FF);
      send_pixel(8'hFF); send_pixel(8'h7F);
      wait_idle();
      load_config(11'd0, 11'd0, 11'd1);
      send_pixel(8'h01); send_pixel(8'h00); send_pixel(8'hFE);
      wait_idle();
      load_config(11'd2047, 11'd2047, 11'd2);
      send_pixel(8'h04); send_pixel(8'h02); send_pixel(8'h00);
      wait_idle();
      load_config(11'd3, 11'd2, 11'd2);
      send_pixel(8'hC3); send_pixel(8'h00); send_pixel(8'h08); send_pixel(8'h00);
      send_pixel(8'h00); send_pixel(8'h11); send_pixel(8'h00); send_pixel(8'h00);
      wait_idle();

      random_sent = 0;
      phase = 0;
      while (random_sent < RANDOM_PIXELS) begin
         phase++;
         tx_burst  = ($urandom_range(0, 2) == 0);
         rx_burst  = ($urandom_range(0, 3) == 0);
         noise     = ($urandom_range(0, 9) == 0);
         empty_pct = $urandom_range(15, 50);
         density   = $urandom_range(30, 100);
         len       = 0;
         if (phase == HOLD_PHASE) begin
            // drop ready for a long stretch while pixels keep coming
            w_val     = 11'd6;
            h_val     = 11'd2;
            len       = 240;
            tx_burst  = 1'b1;
            noise     = 1'b0;
            hold_sink = 1'b1;
         end else if (phase % 12 == 5) begin
            w_val = CSR_DATA_W'($urandom_range(1, 3));
            h_val = $urandom_range(0, 1) ? 11'd256 : 11'd2047;
            len   = $urandom_range(256, 300);
         end else if (phase % 12 == 9) begin
            case ($urandom_range(0, 3))
               0: w_val = 11'd0;
               1: w_val = 11'd1024;
               2: w_val = 11'd2047;
               default: w_val = CSR_DATA_W'($urandom_range(17, 1023));
            endcase
            h_val = CSR_DATA_W'($urandom_range(0, 2));
            len   = $urandom_range(40, 100);
         end else begin
            w_val = CSR_DATA_W'($urandom_range(1, 12));
            h_val = ($urandom_range(0, 9) == 0) ? 11'd0 : CSR_DATA_W'($urandom_range(1, 6));
         end
         h_eff = int'(h_val[IMG_H_W-1:0]);
         if (h_eff < 1) begin
            h_eff = 1;
         end else if (h_eff > MAX_HEIGHT) begin
            h_eff = MAX_HEIGHT;
         end
         case ($urandom_range(0, 6))
            0: m_val = 11'd0;
            1: m_val = 11'h1FF;
            2: m_val = 11'd256;
            3: m_val = CSR_DATA_W'($urandom_range(0, 2047));
            default: m_val = CSR_DATA_W'($urandom_range(0, h_eff));
         endcase
         if (phase == HOLD_PHASE) begin
            m_val = 11'd0;
         end
         if (len == 0) begin
            len = $urandom_range(1, 3) * int'(w_val) * h_eff + $urandom_range(0, 6);
            if (len > 120) begin
               len = 120;
            end
         end

         load_config(w_val, h_val, m_val);
         stim_row = 0;
         repeat (len) begin
            if (stim_row == 0) begin
               empty_col = ($urandom_range(0, 99) < empty_pct);
            end
            if (noise) begin
               px = PIXEL_W'($urandom_range(0, 255));
            end else if (empty_col || $urandom_range(0, 99) >= density) begin
               px = '0;
            end else begin
               px = PIXEL_W'($urandom_range(1, 255));
            end
            send_pixel(px);
            stim_row = (stim_row + 1) % h_eff;
            random_sent++;
         end
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Streamed %0d pixel beats under %0d register settings, incl. clamped sizes",
               pixels_sent, settings_used);
      $display("and mid-column changes; %0d segment beats checked, %0d mismatches.",
               segments_checked, mismatches);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
